@@ hw/rtl/ptq_pkg.sv @@
// Shared types and codes for the periodic timer queue.
// Used by ptq_pick and periodic_timer_queue; depends on nothing else.
package ptq_pkg;

	// Default table size and the cap on firings per tick.
	localparam int TIMER_SLOTS_DEF = 16;
	localparam int MAX_FIRE        = 16;
	localparam int FIRE_W          = $clog2(MAX_FIRE + 1);

	// Field widths.
	localparam int TIME_W = 64;
	localparam int ID_W   = 32;
	localparam int TAG_W  = 16;
	localparam int MODE_W = 2;
	localparam int KIND_W = 2;

	// Input modes.
	localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CANCEL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FULL   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FIRED  = 2'd2;

	// One stored timer.
	typedef struct packed {
		logic [TIME_W-1:0] deadline;
		logic [TIME_W-1:0] period;
		logic              repeat_en;
		logic [ID_W-1:0]   id;
		logic [TAG_W-1:0]  tag;
	} slot_t;

endpackage

@@ hw/rtl/ptq_pick.sv @@
// Ordering unit of the timer queue: decides whether a scanned slot beats the
// current best due timer. Depends on ptq_pkg.
module ptq_pick (
	input  ptq_pkg::slot_t                  cand,
	input  logic                            cand_live,
	input  ptq_pkg::slot_t                  best,
	input  logic                            best_found,
	input  logic [ptq_pkg::TIME_W-1:0]      now_us,
	output logic                            take
);
	import ptq_pkg::*;

	logic due;
	logic earlier;
	logic tie_lower;

	// Compare deadline with now, then with the best so far; ties go to lower id.
	assign due       = cand.deadline <= now_us;
	assign earlier   = cand.deadline < best.deadline;
	assign tie_lower = (cand.deadline == best.deadline) && (cand.id < best.id);
	assign take      = cand_live && due && (!best_found || earlier || tie_lower);

endmodule

@@ hw/rtl/periodic_timer_queue.sv @@
// Periodic timer queue: a table of TIMER_SLOTS timers held in one slot memory.
// Depends on ptq_pkg and ptq_pick.
//
// Use: items enter on in_valid/in_ready, results leave on out_valid/out_ready.
// mode 0 pushes a timer (deadline = now_us) and gives one result: the new id,
// or a table-full result. mode 1 cancels every slot holding cancel_id and
// gives no result. mode 2 ticks: due timers fire earliest first, lower id on
// ties, at most MAX_FIRE per tick, one result each, last set on the final
// one. Periodic timers re-arm at deadline plus period (saturating).
// A push goes through the push state and a cancel scans every slot once. Each
// tick pass reads one slot per cycle through the single registered read port,
// then drains the read register and ends; each firing adds a fire state, and a
// tick that fired ends with an emit state, at MAX_FIRE without a further pass.
// in_ready is high only while the sequencer is idle.
// A firing result is held back until the next pass shows whether it is the
// last; a stalled receiver holds the sequencer where it would load the
// output register, and no result is dropped.
// Reset clears the valid bits, the id counter and all control state; slot
// contents are not cleared and need no clearing pass.
module periodic_timer_queue #(
	parameter int TIMER_SLOTS = ptq_pkg::TIMER_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [63:0] now_us,
	input  logic [63:0] period_us,
	input  logic        periodic,
	input  logic [15:0] user_tag,
	input  logic [31:0] cancel_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [31:0] timer_id,
	output logic [15:0] tag_out,
	output logic [63:0] due_us,
	output logic        last
);
	import ptq_pkg::*;

	localparam int IDX_W = $clog2(TIMER_SLOTS);
	localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_PUSH   = 3'd1;
	localparam logic [2:0] S_CANCEL = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_FIRE   = 3'd4;
	localparam logic [2:0] S_EMIT   = 3'd5;

	// Sequencer and input latches.
	logic [2:0]         state_q;
	logic [TIME_W-1:0]  now_q;
	logic [TIME_W-1:0]  period_q;
	logic               periodic_q;
	logic [TAG_W-1:0]   tag_q;
	logic [ID_W-1:0]    cancel_id_q;
	logic [ID_W-1:0]    next_id_q;

	// Slot table.
	slot_t              mem_q [TIMER_SLOTS];
	logic [TIMER_SLOTS-1:0] valid_q;
	logic [TIMER_SLOTS-1:0] done_q;

	// Scan pipeline.
	logic [CNT_W-1:0]   cnt_q;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	slot_t              rdata_s1;

	// Best due timer of the current pass.
	slot_t              best_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic               best_found_q;
	logic [FIRE_W-1:0]  fire_cnt_q;

	// Firing held until the next pass decides its last flag.
	logic               pend_valid_q;
	logic [ID_W-1:0]    pend_id_q;
	logic [TAG_W-1:0]   pend_tag_q;
	logic [TIME_W-1:0]  pend_due_q;

	// Output register.
	logic               out_valid_q;
	logic [KIND_W-1:0]  kind_q;
	logic [ID_W-1:0]    timer_id_q;
	logic [TAG_W-1:0]   tag_out_q;
	logic [TIME_W-1:0]  due_q;
	logic               last_q;

	logic               in_fire;
	logic               out_free;
	logic               rd_en;
	logic               scan_end;
	logic               cand_live;
	logic               take;
	logic               has_free;
	logic [IDX_W-1:0]   free_idx;
	logic               push_go;
	logic               fire_go;
	logic               emit_go;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_wa;
	slot_t              mem_wd;
	logic [TIME_W:0]    rearm_sum;
	logic [TIME_W-1:0]  rearm_dl;
	logic [FIRE_W-1:0]  fire_nxt;

	assign in_ready  = state_q == S_IDLE;
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign rd_en     = (state_q == S_SCAN || state_q == S_CANCEL) &&
		(cnt_q < CNT_W'(TIMER_SLOTS));
	assign scan_end  = (cnt_q == CNT_W'(TIMER_SLOTS)) && !rd_vld_s1;
	assign push_go   = (state_q == S_PUSH) && out_free;
	assign fire_go   = (state_q == S_FIRE) && (!pend_valid_q || out_free);
	assign emit_go   = (state_q == S_EMIT) && out_free;
	assign fire_nxt  = fire_cnt_q + FIRE_W'(1);

	// Find the lowest free slot.
	always_comb begin
		free_idx = '0;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) free_idx = IDX_W'(i);
		end
	end
	assign has_free = ~&valid_q;

	// Re-armed deadline, saturating at the top of the range.
	assign rearm_sum = {1'b0, best_q.deadline} + {1'b0, best_q.period};
	assign rearm_dl  = rearm_sum[TIME_W] ? {TIME_W{1'b1}} : rearm_sum[TIME_W-1:0];

	// Ordering unit shared by every tick scan step.
	assign cand_live = rd_vld_s1 && valid_q[rd_idx_s1] && !done_q[rd_idx_s1];

	ptq_pick u_pick (
		.cand       (rdata_s1),
		.cand_live  (cand_live),
		.best       (best_q),
		.best_found (best_found_q),
		.now_us     (now_q),
		.take       (take)
	);

	// Select the memory write: new timer on push, new deadline on re-arm.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = free_idx;
		mem_wd = best_q;
		if (push_go && has_free) begin
			mem_we           = 1'b1;
			mem_wd.deadline  = now_q;
			mem_wd.period    = period_q;
			mem_wd.repeat_en = periodic_q;
			mem_wd.id        = next_id_q;
			mem_wd.tag       = tag_q;
		end else if (fire_go && best_q.repeat_en) begin
			mem_we          = 1'b1;
			mem_wa          = best_idx_q;
			mem_wd.deadline = rearm_dl;
		end
	end

	// Slot memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_wa] <= mem_wd;
		rdata_s1 <= mem_q[cnt_q[IDX_W-1:0]];
		rd_idx_s1 <= cnt_q[IDX_W-1:0];
	end

	// Latch the transaction fields.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			now_q       <= now_us;
			period_q    <= period_us;
			periodic_q  <= periodic;
			tag_q       <= user_tag;
			cancel_id_q <= cancel_id;
		end
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			done_q       <= '0;
			cnt_q        <= '0;
			rd_vld_s1    <= 1'b0;
			best_found_q <= 1'b0;
			fire_cnt_q   <= '0;
			pend_valid_q <= 1'b0;
			next_id_q    <= '0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (rd_en) cnt_q <= cnt_q + CNT_W'(1);
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						cnt_q        <= '0;
						best_found_q <= 1'b0;
						done_q       <= '0;
						fire_cnt_q   <= '0;
						pend_valid_q <= 1'b0;
						if (mode == MODE_PUSH) state_q <= S_PUSH;
						else if (mode == MODE_CANCEL) state_q <= S_CANCEL;
						else if (mode == MODE_TICK) state_q <= S_SCAN;
					end
				end
				S_PUSH: begin
					if (push_go) begin
						if (has_free) begin
							valid_q[free_idx] <= 1'b1;
							next_id_q         <= next_id_q + ID_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				S_CANCEL: begin
					// Drop every valid slot that holds the id.
					if (rd_vld_s1 && valid_q[rd_idx_s1] && rdata_s1.id == cancel_id_q)
						valid_q[rd_idx_s1] <= 1'b0;
					if (scan_end) state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (take) best_found_q <= 1'b1;
					if (scan_end) begin
						if (best_found_q) state_q <= S_FIRE;
						else if (pend_valid_q) state_q <= S_EMIT;
						else state_q <= S_IDLE;
					end
				end
				S_FIRE: begin
					if (fire_go) begin
						done_q[best_idx_q] <= 1'b1;
						if (!best_q.repeat_en) valid_q[best_idx_q] <= 1'b0;
						pend_valid_q <= 1'b1;
						fire_cnt_q   <= fire_nxt;
						best_found_q <= 1'b0;
						cnt_q        <= '0;
						if (fire_nxt == FIRE_W'(MAX_FIRE)) state_q <= S_EMIT;
						else state_q <= S_SCAN;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Hold the best candidate of the pass, and the firing awaiting its last flag.
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && take) begin
			best_q     <= rdata_s1;
			best_idx_q <= rd_idx_s1;
		end
		if (fire_go) begin
			pend_id_q  <= best_q.id;
			pend_tag_q <= best_q.tag;
			pend_due_q <= best_q.deadline;
		end
	end

	// Output register: load on push, on a superseded firing and on the final one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_go || (fire_go && pend_valid_q) || emit_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		priority if (push_go) begin
			kind_q     <= has_free ? KIND_ACCEPT : KIND_FULL;
			timer_id_q <= has_free ? next_id_q : '0;
			tag_out_q  <= '0;
			due_q      <= '0;
			last_q     <= 1'b1;
		end else if ((fire_go && pend_valid_q) || emit_go) begin
			kind_q     <= KIND_FIRED;
			timer_id_q <= pend_id_q;
			tag_out_q  <= pend_tag_q;
			due_q      <= pend_due_q;
			last_q     <= emit_go;
		end else begin
			kind_q     <= kind_q;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign timer_id  = timer_id_q;
	assign tag_out   = tag_out_q;
	assign due_us    = due_q;
	assign last      = last_q;

	// The chosen timer of a pass is always a live slot.
	a_best_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && best_found_q) |-> valid_q[best_idx_q])
		else $error("best slot not valid during scan");

	// A held firing exists only inside a tick.
	a_pend_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_PUSH || state_q == S_CANCEL) |-> !pend_valid_q)
		else $error("pending firing outside a tick");

	// A fired slot is never chosen again in the same tick.
	a_done_marked: assert property (@(posedge clk) disable iff (!arst_n)
		fire_go |=> done_q[$past(best_idx_q)])
		else $error("fired slot not marked done");

	// A tick never exceeds its firing cap.
	a_fire_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fire_cnt_q <= FIRE_W'(MAX_FIRE))
		else $error("firing count beyond cap");

endmodule
